// ----- rtl/bcmt_pkg.sv -----
// ---------------------------------------------------------------------------
// Biquad coefficient morph table package
// Shared constants, payload structs, state and command types.
// ---------------------------------------------------------------------------
`default_nettype none

package bcmt_pkg;

  localparam int MAX_FRAMES   = 8;
  localparam int MAX_SECTIONS = 8;
  localparam int COEFS        = 5;
  localparam int HEADER_BYTES = 16;
  localparam int HDR_USED     = 10;
  localparam int STORE_DEPTH  = MAX_FRAMES * MAX_SECTIONS * COEFS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam logic [16:0] MORPH_ONE = 17'h10000;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_COUNTS  = 3'd4;
  localparam logic [2:0] ST_NO_MODEL    = 3'd5;

  localparam logic OP_BYTE = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [7:0]  image_byte;
    logic        image_end;
    logic [16:0] morph;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        model_number;
    logic [7:0]         section_index;
    logic signed [31:0] coef_b0;
    logic signed [31:0] coef_b1;
    logic signed [31:0] coef_b2;
    logic signed [31:0] coef_a1;
    logic signed [31:0] coef_a2;
    logic               final_result;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_POS,
    S_BASE,
    S_READ,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_byte;
    logic emit_load;
    logic emit_nomodel;
    logic q_start;
    logic q_pos;
    logic q_base;
    logic q_mul;
    logic q_acc;
    logic emit_sect;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic model_ok;
    logic last_coef;
    logic last_sec;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/bcmt_ctrl.sv -----
// ---------------------------------------------------------------------------
// Biquad coefficient morph table controller
// Sequences image loading and the per-coefficient steps of a morph query.
// ---------------------------------------------------------------------------
`default_nettype none

module bcmt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  input  wire logic          req_op,
  input  wire logic          req_end,
  input  wire bcmt_pkg::stat_t st,
  output bcmt_pkg::cmd_t     cmd,
  output logic               req_stall
);

  bcmt_pkg::state_t state, state_next;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bcmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    req_stall  = !(state == bcmt_pkg::S_IDLE && !st.out_busy);
    accept     = req_valid && !req_stall;
    cmd        = '0;
    state_next = state;
    case (state)
      bcmt_pkg::S_IDLE: begin
        if (accept) begin
          if (req_op == bcmt_pkg::OP_BYTE) begin
            cmd.load_byte = 1'b1;
            if (req_end) state_next = bcmt_pkg::S_LOAD;
          end else if (!st.model_ok) begin
            cmd.emit_nomodel = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            state_next  = bcmt_pkg::S_POS;
          end
        end
      end
      bcmt_pkg::S_LOAD: begin
        cmd.emit_load = 1'b1;
        state_next    = bcmt_pkg::S_IDLE;
      end
      bcmt_pkg::S_POS: begin
        cmd.q_pos  = 1'b1;
        state_next = bcmt_pkg::S_BASE;
      end
      bcmt_pkg::S_BASE: begin
        cmd.q_base = 1'b1;
        state_next = bcmt_pkg::S_READ;
      end
      bcmt_pkg::S_READ: begin
        state_next = bcmt_pkg::S_MUL;
      end
      bcmt_pkg::S_MUL: begin
        cmd.q_mul  = 1'b1;
        state_next = bcmt_pkg::S_ACC;
      end
      bcmt_pkg::S_ACC: begin
        cmd.q_acc  = 1'b1;
        state_next = st.last_coef ? bcmt_pkg::S_EMIT : bcmt_pkg::S_READ;
      end
      bcmt_pkg::S_EMIT: begin
        if (!st.out_busy) begin
          cmd.emit_sect = 1'b1;
          state_next    = st.last_sec ? bcmt_pkg::S_IDLE : bcmt_pkg::S_READ;
        end
      end
      default: begin
        state_next = bcmt_pkg::S_IDLE;
      end
    endcase
  end

  a_end_loads: assert property (@(posedge clk) disable iff (rst)
    (accept && req_op == bcmt_pkg::OP_BYTE && req_end) |=> state == bcmt_pkg::S_LOAD)
    else $error("End beat did not lead to a load status.");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_sect |-> !st.out_busy)
    else $error("Section result issued over a pending result.");
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    state == bcmt_pkg::S_LOAD |=> st.out_busy)
    else $error("Load status was not presented.");

endmodule

`default_nettype wire

// ----- rtl/bcmt_dp.sv -----
// ---------------------------------------------------------------------------
// Biquad coefficient morph table datapath
// Header parsing, coefficient store, interpolation unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module bcmt_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bcmt_pkg::cmd_t cmd,
  input  wire bcmt_pkg::req_t req,
  input  wire logic           rsp_stall,
  output bcmt_pkg::stat_t     st,
  output logic                rsp_valid,
  output bcmt_pkg::rsp_t      rsp
);

  localparam int AW = bcmt_pkg::ADDR_W;

  logic [31:0] mem [bcmt_pkg::STORE_DEPTH];
  logic [31:0] rd_a, rd_b;
  logic [AW-1:0] addr_a, addr_b;

  logic [7:0]  hdr [bcmt_pkg::HDR_USED];
  logic [31:0] bytes_received;
  logic [7:0]  nf, ns;
  logic [15:0] model_id;
  logic        model_valid;
  logic [2:0]  pending_error;
  logic [23:0] wbuf;

  logic [31:0] off;
  logic [29:0] word;
  logic        wr_en;
  logic [15:0] fs;
  logic [31:0] needed;

  logic [16:0] morph_q;
  logic [24:0] pos;
  logic [7:0]  i0, i1;
  logic [15:0] t;
  logic [19:0] base_a, base_b;
  logic signed [32:0] diff;
  logic signed [49:0] prod;
  logic [31:0] a_q;
  logic [31:0] coef [bcmt_pkg::COEFS];
  logic [2:0]  cidx;
  logic [7:0]  sec;

  assign off    = bytes_received - 32'(bcmt_pkg::HEADER_BYTES);
  assign word   = off[31:2];
  assign wr_en  = cmd.load_byte && bytes_received >= 32'(bcmt_pkg::HEADER_BYTES)
                  && off[1:0] == 2'd3 && word < 30'(bcmt_pkg::STORE_DEPTH);
  assign fs     = 16'(nf) * 16'(ns);
  assign needed = 32'(bcmt_pkg::HEADER_BYTES) + 32'(fs) * 32'(bcmt_pkg::COEFS * 4);
  assign pos    = 25'(morph_q) * 25'(nf - 8'd1);
  assign base_a = 20'(i0) * 20'(ns) * 20'(bcmt_pkg::COEFS);
  assign base_b = 20'(i1) * 20'(ns) * 20'(bcmt_pkg::COEFS);
  assign diff   = $signed({rd_b[31], rd_b}) - $signed({rd_a[31], rd_a});

  assign st.out_busy  = rsp_valid;
  assign st.model_ok  = model_valid && nf != 8'd0 && ns != 8'd0;
  assign st.last_coef = cidx == 3'(bcmt_pkg::COEFS - 1);
  assign st.last_sec  = sec == ns - 8'd1;

  always_ff @(posedge clk) begin
    if (wr_en) mem[word[AW-1:0]] <= {req.image_byte, wbuf};
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte && bytes_received >= 32'(bcmt_pkg::HEADER_BYTES)
        && off[1:0] != 2'd3) begin
      wbuf[off[1:0]*8 +: 8] <= req.image_byte;
    end
    if (cmd.load_byte && bytes_received < 32'(bcmt_pkg::HDR_USED)) begin
      hdr[bytes_received[3:0]] <= req.image_byte;
    end
    if (cmd.q_start) begin
      morph_q <= (req.morph > bcmt_pkg::MORPH_ONE) ? bcmt_pkg::MORPH_ONE : req.morph;
    end
    if (cmd.q_pos) begin
      i0 <= 8'(pos[24:16]);
      i1 <= (8'(pos[24:16]) >= nf - 8'd1) ? 8'(pos[24:16]) : 8'(pos[24:16]) + 8'd1;
      t  <= pos[15:0];
    end
    if (cmd.q_base) begin
      addr_a <= base_a[AW-1:0];
      addr_b <= base_b[AW-1:0];
      cidx   <= '0;
      sec    <= '0;
    end
    if (cmd.q_mul) begin
      prod <= diff * $signed({1'b0, t});
      a_q  <= rd_a;
    end
    if (cmd.q_acc) begin
      coef[cidx] <= a_q + prod[47:16];
      cidx       <= cidx + 3'd1;
      addr_a     <= addr_a + AW'(1);
      addr_b     <= addr_b + AW'(1);
    end
    if (cmd.emit_sect) begin
      cidx <= '0;
      sec  <= sec + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_received <= '0;
      nf             <= '0;
      ns             <= '0;
      model_id       <= '0;
      model_valid    <= 1'b0;
      pending_error  <= '0;
    end else if (cmd.load_byte) begin
      if (bytes_received == 32'd0) model_valid <= 1'b0;
      if (bytes_received != 32'hFFFF_FFFF) bytes_received <= bytes_received + 32'd1;
      if (bytes_received == 32'(bcmt_pkg::HEADER_BYTES - 1)) begin
        model_id <= {hdr[7], hdr[6]};
        nf       <= '0;
        ns       <= '0;
        if (hdr[0] != 8'h5A || hdr[1] != 8'h4D || hdr[2] != 8'h46 || hdr[3] != 8'h31) begin
          pending_error <= bcmt_pkg::ST_BAD_MAGIC;
        end else if (hdr[4] != 8'd1 || hdr[5] != 8'd0) begin
          pending_error <= bcmt_pkg::ST_BAD_VERSION;
        end else if (hdr[8] > 8'(bcmt_pkg::MAX_FRAMES)
                     || hdr[9] > 8'(bcmt_pkg::MAX_SECTIONS)) begin
          pending_error <= bcmt_pkg::ST_BAD_COUNTS;
        end else begin
          pending_error <= bcmt_pkg::ST_OK;
          nf            <= hdr[8];
          ns            <= hdr[9];
        end
      end
    end else if (cmd.emit_load) begin
      bytes_received <= '0;
      pending_error  <= '0;
      if (bytes_received >= 32'(bcmt_pkg::HEADER_BYTES) && pending_error == 3'd0
          && bytes_received >= needed) begin
        model_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.emit_nomodel || cmd.emit_sect) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.emit_nomodel) begin
      rsp              <= '0;
      rsp.final_result <= 1'b1;
      if (cmd.emit_nomodel) begin
        rsp.status <= bcmt_pkg::ST_NO_MODEL;
      end else if (bytes_received < 32'(bcmt_pkg::HEADER_BYTES)) begin
        rsp.status <= bcmt_pkg::ST_TOO_SHORT;
      end else begin
        rsp.model_number <= model_id;
        if (pending_error != 3'd0) begin
          rsp.status <= pending_error;
        end else if (bytes_received < needed) begin
          rsp.status <= bcmt_pkg::ST_TOO_SHORT;
        end else begin
          rsp.status <= bcmt_pkg::ST_OK;
        end
      end
    end else if (cmd.emit_sect) begin
      rsp.status        <= bcmt_pkg::ST_OK;
      rsp.model_number  <= '0;
      rsp.section_index <= sec;
      rsp.coef_b0       <= coef[0];
      rsp.coef_b1       <= coef[1];
      rsp.coef_b2       <= coef[2];
      rsp.coef_a1       <= coef[3];
      rsp.coef_a2       <= coef[4];
      rsp.final_result  <= st.last_sec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/biquad_coefficient_morph_table.sv -----
// An image byte is stored when it is accepted, and the beat that ends an
// image moves on to a load state that produces its load status. A morph
// query first locates its frames (position and base steps) and then works
// through each section: three steps per coefficient (read, multiply and
// accumulate, on the multiplier all coefficients share), then an emit step.
// The block takes a new beat only after the previous result has been taken.
// ---------------------------------------------------------------------------
// Biquad coefficient morph table
// Loads coefficient images and returns interpolated biquad sections.
// ---------------------------------------------------------------------------
`default_nettype none

module biquad_coefficient_morph_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire bcmt_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output bcmt_pkg::rsp_t      rsp
);

  bcmt_pkg::cmd_t  cmd;
  bcmt_pkg::stat_t st;

  bcmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_op    (req.operation),
    .req_end   (req.image_end),
    .st        (st),
    .cmd       (cmd),
    .req_stall (req_stall)
  );

  bcmt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .rsp_stall (rsp_stall),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Morph table testbench
// Loads model images, good and broken, and sends morph queries. Every result
// beat is checked against an in-bench prediction of the block.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int FLAW_NONE    = 0;
  localparam int FLAW_MAGIC   = 1;
  localparam int FLAW_VERSION = 2;
  localparam int FLAW_COUNTS  = 3;
  localparam int FLAW_SHORT   = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  bcmt_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  bcmt_pkg::rsp_t rsp;

  bcmt_pkg::req_t pending_beats[$];
  bcmt_pkg::rsp_t expected_results[$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_off = 0;

  logic [31:0] coef_mem[bcmt_pkg::STORE_DEPTH];
  logic [7:0]  hdr_bytes[16];
  logic [31:0] byte_count;
  logic [7:0]  num_frames;
  logic [7:0]  num_sections;
  logic [15:0] model_id;
  logic        model_ok;
  logic [2:0]  load_error;

  biquad_coefficient_morph_table dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bcmt_pkg::rsp_t single_result(logic [2:0] st, logic [15:0] id);
    bcmt_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.model_number = id;
    r.final_result = 1'b1;
    return r;
  endfunction

  function automatic logic [31:0] blend(logic [31:0] ua, logic [31:0] ub, int unsigned t);
    longint a;
    longint b;
    longint prod;
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    prod = (b - a) * longint'(t);
    return 32'(a + (prod >>> 16));
  endfunction

  task automatic predict_beat(bcmt_pkg::req_t b);
    bcmt_pkg::rsp_t r;
    int unsigned pos;
    int unsigned off;
    int unsigned needed;
    int unsigned nf;
    int unsigned ns;
    int unsigned i0;
    int unsigned i1;
    int unsigned t;
    int unsigned m;
    logic [31:0] va;
    logic [31:0] vb;
    logic [31:0] c[bcmt_pkg::COEFS];
    if (b.operation == bcmt_pkg::OP_BYTE) begin
      pos = byte_count;
      if (pos == 0) model_ok = 1'b0;
      if (pos < bcmt_pkg::HEADER_BYTES) begin
        hdr_bytes[pos] = b.image_byte;
        if (pos == bcmt_pkg::HEADER_BYTES - 1) begin
          model_id = {hdr_bytes[7], hdr_bytes[6]};
          num_frames = '0;
          num_sections = '0;
          if ({hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]} != 32'h31464D5A)
            load_error = bcmt_pkg::ST_BAD_MAGIC;
          else if (hdr_bytes[4] != 8'd1 || hdr_bytes[5] != 8'd0)
            load_error = bcmt_pkg::ST_BAD_VERSION;
          else if (hdr_bytes[8] > bcmt_pkg::MAX_FRAMES
                   || hdr_bytes[9] > bcmt_pkg::MAX_SECTIONS)
            load_error = bcmt_pkg::ST_BAD_COUNTS;
          else begin
            load_error = bcmt_pkg::ST_OK;
            num_frames = hdr_bytes[8];
            num_sections = hdr_bytes[9];
          end
        end
      end else begin
        off = pos - bcmt_pkg::HEADER_BYTES;
        if ((off >> 2) < bcmt_pkg::STORE_DEPTH)
          coef_mem[off >> 2][(off & 3) * 8 +: 8] = b.image_byte;
      end
      if (byte_count != 32'hFFFF_FFFF) byte_count++;
      if (b.image_end) begin
        needed = bcmt_pkg::HEADER_BYTES + num_frames * num_sections * bcmt_pkg::COEFS * 4;
        if (byte_count < bcmt_pkg::HEADER_BYTES)
          r = single_result(bcmt_pkg::ST_TOO_SHORT, '0);
        else if (load_error != bcmt_pkg::ST_OK) r = single_result(load_error, model_id);
        else if (byte_count < needed) r = single_result(bcmt_pkg::ST_TOO_SHORT, model_id);
        else begin
          model_ok = 1'b1;
          r = single_result(bcmt_pkg::ST_OK, model_id);
        end
        expected_results.push_back(r);
        byte_count = '0;
        load_error = bcmt_pkg::ST_OK;
      end
    end else begin
      nf = num_frames;
      ns = num_sections;
      if (!model_ok || nf == 0 || ns == 0) begin
        expected_results.push_back(single_result(bcmt_pkg::ST_NO_MODEL, '0));
      end else begin
        i0 = 0;
        i1 = 0;
        t = 0;
        if (nf > 1) begin
          m = (b.morph > bcmt_pkg::MORPH_ONE) ? 65536 : b.morph;
          pos = m * (nf - 1);
          i0 = pos >> 16;
          t = pos & 16'hFFFF;
          i1 = (i0 >= nf - 1) ? i0 : i0 + 1;
        end
        for (int s = 0; s < ns; s++) begin
          for (int k = 0; k < bcmt_pkg::COEFS; k++) begin
            va = coef_mem[(i0 * ns + s) * bcmt_pkg::COEFS + k];
            vb = coef_mem[(i1 * ns + s) * bcmt_pkg::COEFS + k];
            c[k] = blend(va, vb, t);
          end
          r = '0;
          r.section_index = 8'(s);
          r.coef_b0 = c[0];
          r.coef_b1 = c[1];
          r.coef_b2 = c[2];
          r.coef_a1 = c[3];
          r.coef_a2 = c[4];
          r.final_result = (s == ns - 1);
          expected_results.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic add_byte(logic [7:0] v, bit last);
    bcmt_pkg::req_t b;
    b = '0;
    b.operation = bcmt_pkg::OP_BYTE;
    b.image_byte = v;
    b.image_end = last;
    b.morph = 17'($urandom);
    pending_beats.push_back(b);
  endtask

  task automatic add_query(logic [16:0] m);
    bcmt_pkg::req_t b;
    b = '0;
    b.operation = ~bcmt_pkg::OP_BYTE;
    b.morph = m;
    b.image_byte = 8'($urandom);
    b.image_end = 1'($urandom);
    pending_beats.push_back(b);
  endtask

  task automatic add_image(int nf, int ns, int flaw, int extra);
    logic [7:0] h[16];
    int words;
    int total;
    h[0] = 8'h5A; h[1] = 8'h4D; h[2] = 8'h46; h[3] = 8'h31;
    h[4] = 8'd1; h[5] = 8'd0;
    h[6] = 8'($urandom); h[7] = 8'($urandom);
    h[8] = 8'(nf); h[9] = 8'(ns);
    for (int i = 10; i < 16; i++) h[i] = 8'($urandom);
    if (flaw == FLAW_MAGIC) h[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
    if (flaw == FLAW_VERSION) begin
      if ($urandom_range(0, 1)) h[4] = 8'($urandom_range(2, 255));
      else h[5] = 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_COUNTS) begin
      if ($urandom_range(0, 1)) h[8] = 8'($urandom_range(9, 255));
      else h[9] = 8'($urandom_range(9, 255));
    end
    words = nf * ns * bcmt_pkg::COEFS;
    total = 16 + words * 4 + extra;
    if (flaw == FLAW_SHORT) total = $urandom_range(1, 16 + words * 4 - 1);
    for (int i = 0; i < total; i++)
      add_byte(i < 16 ? h[i] : 8'($urandom), i == total - 1);
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || req_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (!(req_valid && req_stall)) begin
        if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= pending_beats[0];
          predict_beat(pending_beats.pop_front());
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    bcmt_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(rsp.status), 32'hFFFF_FFFF);
      end else begin
        want = expected_results.pop_front();
        if (rsp.status != want.status) report_mismatch("status", rsp.status, want.status);
        if (rsp.model_number != want.model_number)
          report_mismatch("model_number", rsp.model_number, want.model_number);
        if (rsp.section_index != want.section_index)
          report_mismatch("section_index", rsp.section_index, want.section_index);
        if (rsp.coef_b0 != want.coef_b0) report_mismatch("coef_b0", rsp.coef_b0, want.coef_b0);
        if (rsp.coef_b1 != want.coef_b1) report_mismatch("coef_b1", rsp.coef_b1, want.coef_b1);
        if (rsp.coef_b2 != want.coef_b2) report_mismatch("coef_b2", rsp.coef_b2, want.coef_b2);
        if (rsp.coef_a1 != want.coef_a1) report_mismatch("coef_a1", rsp.coef_a1, want.coef_a1);
        if (rsp.coef_a2 != want.coef_a2) report_mismatch("coef_a2", rsp.coef_a2, want.coef_a2);
        if (rsp.final_result != want.final_result)
          report_mismatch("final_result", rsp.final_result, want.final_result);
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > 2000000) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    byte_count = '0;
    num_frames = '0;
    num_sections = '0;
    model_id = '0;
    model_ok = 1'b0;
    load_error = bcmt_pkg::ST_OK;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_query(17'h1FFFF);
    add_byte(8'hFF, 1'b1);
    add_image(0, 0, FLAW_MAGIC, 0);
    add_image(0, 0, FLAW_VERSION, 0);
    add_image(0, 0, FLAW_COUNTS, 0);
    add_image(1, 1, FLAW_SHORT, 0);
    add_image(2, 1, FLAW_NONE, 1);
    add_query(17'd0);
    add_query(17'h10000);
    add_query(17'h1FFFF);
    add_query(17'h0FFFF);
    add_image(1, 8, FLAW_NONE, 0);
    add_query(17'd12345);
    add_query(17'h08000);
    add_image(0, 0, FLAW_NONE, 1);
    add_query(17'd100);

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 67; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 67; end
        3: begin send_idle_pct = 22; stall_pct = 22; end
        default: begin send_idle_pct = 0; stall_pct = 0; hold_off <= 300; end
      endcase
      for (int n = 0; n < 2; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          add_image($urandom_range(1, 2), 1,
                    ($urandom_range(0, 4) == 0) ? $urandom_range(FLAW_MAGIC, FLAW_SHORT)
                                                : FLAW_NONE,
                    $urandom_range(0, 2));
        end else begin
          add_query(17'($urandom));
        end
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) add_query(17'($urandom_range(65530, 131071)));
          else add_query(17'($urandom_range(0, 65536)));
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
